// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising edge, off while reset is held.
`define SFR_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define SFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sfr_pkg.sv =====
package sfr_pkg;

	localparam int MAX_FRAME_LEN_DEF = 64;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] SYNC_A = 8'h55;
	localparam logic [7:0] SYNC_B = 8'hAA;
	localparam logic [15:0] CHECK_INIT = 16'hFFFF;
	localparam logic [15:0] MIN_FRAME_LEN = 16'd7;

	localparam logic [1:0] MODE_ZERO = 2'd0;
	localparam logic [1:0] MODE_XOR = 2'd1;
	localparam logic [1:0] MODE_CRC = 2'd2;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_MISMATCH = 2'd2,
		KIND_BAD_LEN = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SYNC2,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_TYPE,
		PH_PAYLOAD,
		PH_CHK_HI,
		PH_CHK_LO
	} phase_t;

	// One result as it leaves the parser, before output formatting.
	typedef struct packed {
		kind_t kind;
		logic [7:0] data;
		logic [7:0] ftype;
		logic [5:0] plen;
	} result_t;

	// Byte-wide CRC-16 update, polynomial 0x1021, no reflection.
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] x;
		begin
			x = crc[15:8] ^ b;
			x = x ^ {4'h0, x[7:4]};
			crc_step = {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
				^ {8'h00, x};
		end
	endfunction

endpackage

// ===== sv/sfr_front.sv =====
module sfr_front #(
	parameter int MAX_FRAME_LEN = sfr_pkg::MAX_FRAME_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] rx_byte,
	input logic [1:0] check_mode,
	input logic q_full,
	output logic push,
	output sfr_pkg::result_t res
);

	// Holds the payload count, 0 to MAX_FRAME_LEN - 7.
	localparam int LenW = $clog2(MAX_FRAME_LEN - 6);

	sfr_pkg::phase_t phase_q, phase_d;
	logic [7:0] len_hi_q;
	logic [7:0] type_q;
	logic [5:0] plen_q;
	logic [LenW-1:0] remain_q;
	logic [15:0] crc_q;
	logic [7:0] xor_q;

	logic fire;
	logic emit;
	logic absorb;
	logic [15:0] len_w;
	logic [15:0] diff_w;
	logic len_bad;
	logic [15:0] exp_chk;

	assign in_ready = !q_full;
	assign fire = in_valid && in_ready;
	assign push = fire && emit;

	assign len_w = {len_hi_q, rx_byte};
	assign diff_w = len_w - sfr_pkg::MIN_FRAME_LEN;
	assign len_bad = (len_w < sfr_pkg::MIN_FRAME_LEN) || (len_w > 16'(MAX_FRAME_LEN));

	always_comb begin
		unique case (check_mode)
			sfr_pkg::MODE_XOR: exp_chk = {8'h00, xor_q};
			sfr_pkg::MODE_CRC: exp_chk = crc_q;
			default: exp_chk = 16'h0000;
		endcase
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			sfr_pkg::PH_HUNT: begin
				if (rx_byte == sfr_pkg::SYNC_A) phase_d = sfr_pkg::PH_SYNC2;
			end
			sfr_pkg::PH_SYNC2: begin
				phase_d = (rx_byte == sfr_pkg::SYNC_B) ? sfr_pkg::PH_LEN_HI : sfr_pkg::PH_HUNT;
			end
			sfr_pkg::PH_LEN_HI: phase_d = sfr_pkg::PH_LEN_LO;
			sfr_pkg::PH_LEN_LO: phase_d = len_bad ? sfr_pkg::PH_HUNT : sfr_pkg::PH_TYPE;
			sfr_pkg::PH_TYPE: begin
				phase_d = (remain_q != '0) ? sfr_pkg::PH_PAYLOAD : sfr_pkg::PH_CHK_HI;
			end
			sfr_pkg::PH_PAYLOAD: begin
				if (remain_q == LenW'(1)) phase_d = sfr_pkg::PH_CHK_HI;
			end
			sfr_pkg::PH_CHK_HI: begin
				phase_d = (rx_byte != exp_chk[15:8]) ? sfr_pkg::PH_HUNT : sfr_pkg::PH_CHK_LO;
			end
			sfr_pkg::PH_CHK_LO: phase_d = sfr_pkg::PH_HUNT;
			default: phase_d = sfr_pkg::PH_HUNT;
		endcase
	end

	// Result and check-absorb decode.
	always_comb begin
		emit = 1'b0;
		absorb = 1'b0;
		res.kind = sfr_pkg::KIND_PAYLOAD;
		res.data = rx_byte;
		res.ftype = type_q;
		res.plen = plen_q;
		unique case (phase_q)
			sfr_pkg::PH_HUNT: absorb = 1'b0;
			sfr_pkg::PH_SYNC2: absorb = (rx_byte == sfr_pkg::SYNC_B);
			sfr_pkg::PH_LEN_HI: absorb = 1'b1;
			sfr_pkg::PH_LEN_LO: begin
				absorb = 1'b1;
				emit = len_bad;
				res.kind = sfr_pkg::KIND_BAD_LEN;
			end
			sfr_pkg::PH_TYPE: absorb = 1'b1;
			sfr_pkg::PH_PAYLOAD: begin
				absorb = 1'b1;
				emit = 1'b1;
			end
			sfr_pkg::PH_CHK_HI: begin
				emit = (rx_byte != exp_chk[15:8]);
				res.kind = sfr_pkg::KIND_MISMATCH;
			end
			sfr_pkg::PH_CHK_LO: begin
				emit = 1'b1;
				res.kind = (rx_byte == exp_chk[7:0]) ? sfr_pkg::KIND_ACCEPT
					: sfr_pkg::KIND_MISMATCH;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfr_pkg::PH_HUNT;
			len_hi_q <= 8'h00;
			type_q <= 8'h00;
			plen_q <= 6'd0;
			remain_q <= '0;
			crc_q <= sfr_pkg::CHECK_INIT;
			xor_q <= 8'h00;
		end else if (fire) begin
			phase_q <= phase_d;
			if (phase_q == sfr_pkg::PH_HUNT && rx_byte == sfr_pkg::SYNC_A) begin
				crc_q <= sfr_pkg::crc_step(sfr_pkg::CHECK_INIT, rx_byte);
				xor_q <= rx_byte;
			end else if (absorb) begin
				crc_q <= sfr_pkg::crc_step(crc_q, rx_byte);
				xor_q <= xor_q ^ rx_byte;
			end
			if (phase_q == sfr_pkg::PH_LEN_HI) len_hi_q <= rx_byte;
			if (phase_q == sfr_pkg::PH_LEN_LO) begin
				remain_q <= diff_w[LenW-1:0];
				plen_q <= diff_w[5:0];
			end
			if (phase_q == sfr_pkg::PH_TYPE) type_q <= rx_byte;
			if (phase_q == sfr_pkg::PH_PAYLOAD) remain_q <= remain_q - LenW'(1);
		end
	end

endmodule

// ===== sv/sfr_queue.sv =====
module sfr_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sfr_pkg::result_t wr_data,
	output logic full,
	input logic pop,
	output logic not_empty,
	output sfr_pkg::result_t rd_data
);

	localparam int Depth = sfr_pkg::QUEUE_DEPTH;
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	sfr_pkg::result_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) count_q <= count_q + CntW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CntW'(1);
		end
	end

endmodule

// ===== sv/sfr_back.sv =====
module sfr_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input sfr_pkg::result_t rec,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] frame_type,
	output logic [5:0] payload_len
);

	logic valid_q;
	sfr_pkg::result_t out_q;
	sfr_pkg::result_t fmt;

	// Only payload results carry a byte; a bad length knows no frame.
	always_comb begin
		fmt = rec;
		if (rec.kind != sfr_pkg::KIND_PAYLOAD) fmt.data = 8'h00;
		if (rec.kind == sfr_pkg::KIND_BAD_LEN) begin
			fmt.ftype = 8'h00;
			fmt.plen = 6'd0;
		end
	end

	assign pop = q_valid && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) out_q <= fmt;
	end

	assign out_valid = valid_q;
	assign kind = out_q.kind;
	assign data_byte = out_q.data;
	assign frame_type = out_q.ftype;
	assign payload_len = out_q.plen;

endmodule

// ===== sv/sync_crc_frame_receiver.sv =====
// Sync-framed byte receiver with a selectable frame check.
// Received bytes enter on the input channel (in_valid, in_ready, rx_byte), one
// transaction per byte. The parser hunts for the sync pair 0x55 0xAA, then reads a
// 16-bit total length, a type byte, the payload and a 16-bit check, high byte first.
// Each payload byte produces one result transaction on the output channel (kind,
// data_byte, frame_type, payload_len); the end of a frame produces an accept or a
// mismatch result, and a length outside 7 to MAX_FRAME_LEN produces a bad-length
// result right after the low length byte. All other bytes produce nothing.
// The configuration channel (cfg_valid, cfg_ready, check_mode) selects the check:
// zero, an 8-bit XOR, or CRC-16 with polynomial 0x1021 and initial value 0xFFFF.
// It is always ready and should only be written while the receiver is idle.
// Throughput is one byte per cycle while the result queue has room: the parser
// updates the CRC as each byte is accepted. A result is written into the result
// queue when its byte is accepted and then moves on to the output register.
// Reset returns the parser to hunting, selects the CRC check and empties the queue.
// If the output stalls, the queue takes the next result, and in_ready falls only
// once the queue is full; bytes that produce no result still pass while it has room.
module sync_crc_frame_receiver #(
	parameter int MAX_FRAME_LEN = sfr_pkg::MAX_FRAME_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] check_mode,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] frame_type,
	output logic [5:0] payload_len
);

	logic [1:0] mode_q;
	logic q_full;
	logic q_not_empty;
	logic push;
	logic pop;
	sfr_pkg::result_t front_res;
	sfr_pkg::result_t queue_res;

	// The check mode register is only sampled when the check bytes arrive.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sfr_pkg::MODE_CRC;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= check_mode;
		end
	end

	// Front: byte parser, running checks and result classification.
	sfr_front #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.check_mode(mode_q),
		.q_full(q_full),
		.push(push),
		.res(front_res)
	);

	// Short result queue so the parser keeps going while the output stalls.
	sfr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(front_res),
		.full(q_full),
		.pop(pop),
		.not_empty(q_not_empty),
		.rd_data(queue_res)
	);

	// Back: formats results and holds them in the output register.
	sfr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_not_empty),
		.rec(queue_res),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.frame_type(frame_type),
		.payload_len(payload_len)
	);

endmodule

// ===== sv/sfr_checker.sv =====
`include "assert_macros.svh"

module sfr_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_ready,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] kind,
	input logic [7:0] data_byte,
	input logic [7:0] frame_type,
	input logic [5:0] payload_len
);

	// Only payload results carry a data byte.
	`SFR_ASSERT_IMPL(a_data_zero, clk, arst_n, out_valid && kind != sfr_pkg::KIND_PAYLOAD, data_byte == 8'h00, "data_byte set on a non-payload result")

	// A bad length has no frame type or payload length.
	`SFR_ASSERT_IMPL(a_badlen_fields, clk, arst_n, out_valid && kind == sfr_pkg::KIND_BAD_LEN, frame_type == 8'h00 && payload_len == 6'd0, "bad-length result carries frame fields")

	// The input only stalls behind a result waiting at the output.
	`SFR_ASSERT_IMPL(a_stall_cause, clk, arst_n, !in_ready, out_valid, "input stalled with no result pending")

	// A stalled result holds.
	`SFR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(data_byte) && $stable(frame_type) && $stable(payload_len), "stalled result changed")

	// The configuration port never stalls.
	`SFR_ASSERT(a_cfg_ready, clk, arst_n, cfg_ready, "configuration port not ready")

endmodule

bind sync_crc_frame_receiver sfr_checker u_sfr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cfg_ready(cfg_ready),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.kind(kind),
	.data_byte(data_byte),
	.frame_type(frame_type),
	.payload_len(payload_len)
);
